FILE: sv/alarm_system_controller_defines.svh
// ----------------------------------------------------------------------------
// Alarm system controller assertion macros
// Same-cycle and next-cycle implication checks, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ALARM_SYSTEM_CONTROLLER_DEFINES_SVH
`define ALARM_SYSTEM_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// Check that pre implies post in the same cycle
`define ASC_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("alarm controller check failed");
// Check that pre implies post in the next cycle
`define ASC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("alarm controller check failed");
`else
`define ASC_ASSERT_NOW(lbl, pre, post)
`define ASC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: sv/alarm_pkg.sv
// ----------------------------------------------------------------------------
// Alarm controller package
// Mode codes, sound phases, lamp bits and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package alarm_pkg;

    // Operating mode, also the value shown on the mode output
    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_ARMING    = 3'd1,
        MODE_ARMED     = 3'd2,
        MODE_TRIGGERED = 3'd3,
        MODE_SOUNDING  = 3'd4
    } t_mode;

    // Phase within sounding
    typedef enum logic [1:0] {
        PH_ON   = 2'd0,
        PH_OFF  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ARM_DELAY   = 2'd0,
        CFG_ALARM_DELAY = 2'd1,
        CFG_SOUND_ON    = 2'd2,
        CFG_SOUND_OFF   = 2'd3
    } t_cfg_index;

    // Lamp vector bits: led one, led two, buzzer
    localparam logic [2:0] LAMP_ONE  = 3'b001;
    localparam logic [2:0] LAMP_TWO  = 3'b010;
    localparam logic [2:0] LAMP_BUZZ = 3'b100;
    localparam logic [2:0] LAMP_NONE = 3'b000;

    // Register reset values
    localparam logic [7:0] ARM_DELAY_RST   = 8'd10;
    localparam logic [7:0] ALARM_DELAY_RST = 8'd10;
    localparam logic [7:0] SOUND_ON_RST    = 8'd2;
    localparam logic [7:0] SOUND_OFF_RST   = 8'd2;

    localparam logic [7:0] SECONDS_MAX = 8'hFF;

endpackage

`default_nettype wire

FILE: sv/alarm_system_controller.sv
// ----------------------------------------------------------------------------
// Alarm system controller
// Five-mode intrusion alarm driven by pin samples and tick pulses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sample: button level
//   (0 pressed), sensor level, one-second and half-second tick pulses.
//   Output channel (o_out_valid / i_out_ready) returns one result per sample:
//   lamp and buzzer levels, mode code and a one-result notify pulse.
//   The result register loads at the edge that takes the sample. Throughput
//   is one sample per cycle while the receiver keeps up; the mode update is a
//   single short next-state step from the state registers.
//   A new sample is taken while a result is still waiting, as long as that
//   result is taken in the same cycle; if the receiver stalls, the result
//   holds and o_in_ready drops until it is taken.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered;
//   they are to be made while the block is idle, which it does not enforce.
//   Synchronous reset: mode off with entry actions pending, button released,
//   delays 10/10 and sound phases 2/2 seconds, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alarm_system_controller_defines.svh"

module alarm_system_controller (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // sample channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_button_level,
    input  wire logic       i_sensor_level,
    input  wire logic       i_second_pulse,
    input  wire logic       i_half_second_pulse,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_led_one,
    output logic            o_led_two,
    output logic            o_buzzer_on,
    output logic [2:0]      o_mode_code,
    output logic            o_notify_pulse
);

    // configuration registers
    logic [7:0] r_arm_delay;
    logic [7:0] r_alarm_delay;
    logic [7:0] r_sound_on;
    logic [7:0] r_sound_off;

    // machine state
    alarm_pkg::t_mode  r_mode,    n_mode;
    alarm_pkg::t_phase r_phase,   n_phase;
    logic              r_entry,   n_entry;
    logic              r_prior_button;
    logic [7:0]        r_elapsed, n_elapsed;
    logic              r_blink,   n_blink;
    logic [2:0]        r_lamps,   n_lamps;
    logic              n_notify;

    // result register
    logic       r_out_valid;
    logic [2:0] r_out_lamps;
    logic [2:0] r_out_mode;
    logic       r_out_notify;

    logic in_accept;
    logic press;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign press      = r_prior_button && !i_button_level;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_delay   <= alarm_pkg::ARM_DELAY_RST;
            r_alarm_delay <= alarm_pkg::ALARM_DELAY_RST;
            r_sound_on    <= alarm_pkg::SOUND_ON_RST;
            r_sound_off   <= alarm_pkg::SOUND_OFF_RST;
        end else if (i_cfg_we) begin
            case (alarm_pkg::t_cfg_index'(i_cfg_index))
                alarm_pkg::CFG_ARM_DELAY:   r_arm_delay   <= i_cfg_data;
                alarm_pkg::CFG_ALARM_DELAY: r_alarm_delay <= i_cfg_data;
                alarm_pkg::CFG_SOUND_ON:    r_sound_on    <= i_cfg_data;
                alarm_pkg::CFG_SOUND_OFF:   r_sound_off   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Compute next state and result for the current sample
    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_entry   = 1'b0;
        n_elapsed = r_elapsed;
        n_blink   = r_blink;
        n_lamps   = r_lamps;
        n_notify  = 1'b0;

        // entry actions, or advance the seconds count
        if (r_entry) begin
            n_elapsed = '0;
            case (r_mode)
                alarm_pkg::MODE_ARMING:    n_lamps = r_lamps & ~alarm_pkg::LAMP_ONE;
                alarm_pkg::MODE_ARMED:
                    n_lamps = (r_lamps & alarm_pkg::LAMP_BUZZ) | alarm_pkg::LAMP_TWO;
                alarm_pkg::MODE_TRIGGERED: begin
                    n_lamps = alarm_pkg::LAMP_ONE | alarm_pkg::LAMP_TWO;
                    n_blink = 1'b1;
                end
                alarm_pkg::MODE_SOUNDING: begin
                    n_lamps = alarm_pkg::LAMP_ONE | alarm_pkg::LAMP_TWO
                            | alarm_pkg::LAMP_BUZZ;
                    n_phase = alarm_pkg::PH_ON;
                end
                default:                   n_lamps = alarm_pkg::LAMP_ONE;
            endcase
        end else if (i_second_pulse && r_elapsed != alarm_pkg::SECONDS_MAX) begin
            n_elapsed = r_elapsed + 8'd1;
        end

        // mode tick actions and delay moves
        case (r_mode)
            alarm_pkg::MODE_ARMING: begin
                if (!r_entry && i_half_second_pulse) begin
                    n_lamps = n_lamps ^ alarm_pkg::LAMP_ONE;
                end
                if (n_elapsed >= r_arm_delay) begin
                    n_mode  = alarm_pkg::MODE_ARMED;
                    n_entry = 1'b1;
                end
            end
            alarm_pkg::MODE_ARMED: begin
                if (i_sensor_level) begin
                    n_mode  = alarm_pkg::MODE_TRIGGERED;
                    n_entry = 1'b1;
                end
            end
            alarm_pkg::MODE_TRIGGERED: begin
                if (!r_entry && i_second_pulse) begin
                    n_blink = !r_blink;
                    n_lamps = n_blink ? (alarm_pkg::LAMP_ONE | alarm_pkg::LAMP_TWO)
                                      : alarm_pkg::LAMP_NONE;
                end
                if (n_elapsed >= r_alarm_delay) begin
                    n_mode  = alarm_pkg::MODE_SOUNDING;
                    n_entry = 1'b1;
                end
            end
            alarm_pkg::MODE_SOUNDING: begin
                case (n_phase)
                    alarm_pkg::PH_ON: begin
                        if (n_elapsed >= r_sound_on) begin
                            n_lamps   = alarm_pkg::LAMP_NONE;
                            n_elapsed = '0;
                            n_phase   = alarm_pkg::PH_OFF;
                        end
                    end
                    alarm_pkg::PH_OFF: begin
                        if (n_elapsed >= r_sound_off) begin
                            n_notify = 1'b1;
                            n_phase  = alarm_pkg::PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                if (press) begin
                    n_mode  = alarm_pkg::MODE_ARMING;
                    n_entry = 1'b1;
                end
            end
        endcase

        // a press disarms from armed, triggered or sounding
        if (press && (r_mode == alarm_pkg::MODE_ARMED
                   || r_mode == alarm_pkg::MODE_TRIGGERED
                   || r_mode == alarm_pkg::MODE_SOUNDING)) begin
            n_mode  = alarm_pkg::MODE_OFF;
            n_entry = 1'b1;
        end
    end

    // Advance machine state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= alarm_pkg::MODE_OFF;
            r_phase        <= alarm_pkg::PH_ON;
            r_entry        <= 1'b1;
            r_prior_button <= 1'b1;
            r_elapsed      <= '0;
            r_blink        <= 1'b1;
            r_lamps        <= alarm_pkg::LAMP_NONE;
        end else if (in_accept) begin
            r_mode         <= n_mode;
            r_phase        <= n_phase;
            r_entry        <= n_entry;
            r_prior_button <= i_button_level;
            r_elapsed      <= n_elapsed;
            r_blink        <= n_blink;
            r_lamps        <= n_lamps;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_lamps  <= n_lamps;
            r_out_mode   <= n_mode;
            r_out_notify <= n_notify;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_led_one      = r_out_lamps[0];
    assign o_led_two      = r_out_lamps[1];
    assign o_buzzer_on    = r_out_lamps[2];
    assign o_mode_code    = r_out_mode;
    assign o_notify_pulse = r_out_notify;

    // notify only ever leaves sounding in its done phase
    `ASC_ASSERT_NEXT(a_notify_done, in_accept && n_notify, r_phase == alarm_pkg::PH_DONE)
    // entry actions run exactly once per mode change
    `ASC_ASSERT_NEXT(a_entry_once, in_accept && r_entry,
                     !r_entry || r_mode != $past(r_mode))
    // buzzer sounds only in sounding, or on the step that disarms it
    `ASC_ASSERT_NOW(a_buzz_mode, r_lamps[2],
                    r_mode == alarm_pkg::MODE_SOUNDING || r_mode == alarm_pkg::MODE_OFF)

endmodule

`default_nettype wire

FILE: dv/tb_alarm_system_controller.sv
// ----------------------------------------------------------------------------
// Alarm system controller testbench
// A short table of directed samples and then random samples are sent through
// the sample channel. Each result is checked against an in-bench model of the
// five-mode alarm, run under several delay settings. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_alarm_system_controller;

    // One result as seen on the result channel
    typedef struct packed {
        logic             led_one;
        logic             led_two;
        logic             buzzer;
        alarm_pkg::t_mode mode;
        logic             notify;
    } t_alarm_result;

    // One directed request; want is used only where typed is set
    typedef struct packed {
        logic          btn;
        logic          sens;
        logic          sec;
        logic          half;
        logic          typed;
        t_alarm_result want;
    } t_sample_row;

    localparam t_alarm_result NO_RESULT = '0;
    localparam int            NUM_ROWS  = 22;
    localparam int            NUM_SETS  = 6;
    localparam int            LAST_SET  = NUM_SETS - 1;

    // Directed walk with arm 1, alarm 1, sound on 1, sound off 0
    localparam t_sample_row DIRECTED [NUM_ROWS] = '{
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, alarm_pkg::MODE_OFF, 1'b0}},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},  // press: off to arming
        '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, NO_RESULT},  // arming entry ignores ticks
        '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},  // half tick blinks
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, NO_RESULT},  // press while arming
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, NO_RESULT},  // arm delay done
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, NO_RESULT},  // armed entry
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT},  // press beats sensor
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, NO_RESULT},  // sensor hit
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, NO_RESULT},  // triggered entry
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, NO_RESULT},  // blink, alarm delay done
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},  // sounding entry
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, NO_RESULT},  // on phase ends
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
          '{1'b0, 1'b0, 1'b0, alarm_pkg::MODE_SOUNDING, 1'b1}},
        '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, NO_RESULT},  // done, waits
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT},  // press: back to off
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, NO_RESULT}
    };

    // Random phases: register settings, request count, second tick percent
    localparam logic [7:0] SET_ARM   [NUM_SETS] = '{8'd1, 8'd1, 8'd255, 8'd1, 8'd1, 8'd10};
    localparam logic [7:0] SET_ALARM [NUM_SETS] = '{8'd1, 8'd1, 8'd1, 8'd255, 8'd1, 8'd10};
    localparam logic [7:0] SET_ON    [NUM_SETS] = '{8'd0, 8'd0, 8'd1, 8'd2, 8'd0, 8'd2};
    localparam logic [7:0] SET_OFF   [NUM_SETS] = '{8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 8'd2};
    localparam int         SET_COUNT [NUM_SETS] = '{150, 200, 380, 330, 330, 250};
    localparam int         SET_SEC   [NUM_SETS] = '{50, 50, 90, 90, 90, 60};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    alarm_pkg::t_cfg_index cfg_index;
    logic [7:0]            cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  btn_level;
    logic                  sensor_level;
    logic                  second_pulse;
    logic                  half_pulse;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  led_one;
    logic                  led_two;
    logic                  buzzer_on;
    logic [2:0]            mode_code;
    logic                  notify_pulse;

    // Model state and register copy, at their reset values
    alarm_pkg::t_mode  cur_mode   = alarm_pkg::MODE_OFF;
    logic              entry_pend = 1'b1;
    logic              prior_btn  = 1'b1;
    logic [7:0]        secs       = 8'd0;
    logic              blink      = 1'b1;
    alarm_pkg::t_phase phase      = alarm_pkg::PH_ON;
    logic [2:0]        lamps      = alarm_pkg::LAMP_NONE;
    logic [7:0]        arm_delay   = alarm_pkg::ARM_DELAY_RST;
    logic [7:0]        alarm_delay = alarm_pkg::ALARM_DELAY_RST;
    logic [7:0]        sound_on    = alarm_pkg::SOUND_ON_RST;
    logic [7:0]        sound_off   = alarm_pkg::SOUND_OFF_RST;

    t_alarm_result pending_outputs [$];
    logic          no_idle   = 1'b0;
    logic          long_hold = 1'b0;
    int            samples_sent    = 0;
    int            results_checked = 0;
    int            notify_seen     = 0;
    int            settings_used   = 0;
    int            errors          = 0;

    always #5 clk = ~clk;

    alarm_system_controller i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_button_level      (btn_level),
        .i_sensor_level      (sensor_level),
        .i_second_pulse      (second_pulse),
        .i_half_second_pulse (half_pulse),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_led_one           (led_one),
        .o_led_two           (led_two),
        .o_buzzer_on         (buzzer_on),
        .o_mode_code         (mode_code),
        .o_notify_pulse      (notify_pulse)
    );

    // Advance the alarm model by one sample and return its result
    function automatic t_alarm_result alarm_next(logic btn, logic sens, logic sec,
                                                 logic half);
        t_alarm_result    r;
        logic             press;
        logic             entering;
        logic             notify;
        alarm_pkg::t_mode cur;
        press    = prior_btn && !btn;
        entering = entry_pend;
        notify   = 1'b0;
        cur      = cur_mode;
        prior_btn = btn;

        // Run entry actions, or count a second
        if (entering) begin
            entry_pend = 1'b0;
            secs = 8'd0;
            case (cur)
                alarm_pkg::MODE_ARMING: lamps = lamps & ~alarm_pkg::LAMP_ONE;
                alarm_pkg::MODE_ARMED:
                    lamps = (lamps & alarm_pkg::LAMP_BUZZ) | alarm_pkg::LAMP_TWO;
                alarm_pkg::MODE_TRIGGERED: begin
                    lamps = alarm_pkg::LAMP_ONE | alarm_pkg::LAMP_TWO;
                    blink = 1'b1;
                end
                alarm_pkg::MODE_SOUNDING: begin
                    lamps = alarm_pkg::LAMP_ONE | alarm_pkg::LAMP_TWO
                          | alarm_pkg::LAMP_BUZZ;
                    phase = alarm_pkg::PH_ON;
                end
                default: lamps = alarm_pkg::LAMP_ONE;
            endcase
        end else if (sec && secs != alarm_pkg::SECONDS_MAX) begin
            secs = secs + 8'd1;
        end

        // Apply tick actions and delay moves
        case (cur)
            alarm_pkg::MODE_ARMING: begin
                if (!entering && half)
                    lamps = lamps ^ alarm_pkg::LAMP_ONE;
                if (secs >= arm_delay) begin
                    cur_mode = alarm_pkg::MODE_ARMED;
                    entry_pend = 1'b1;
                end
            end
            alarm_pkg::MODE_ARMED: begin
                if (sens) begin
                    cur_mode = alarm_pkg::MODE_TRIGGERED;
                    entry_pend = 1'b1;
                end
            end
            alarm_pkg::MODE_TRIGGERED: begin
                if (!entering && sec) begin
                    blink = !blink;
                    lamps = blink ? (alarm_pkg::LAMP_ONE | alarm_pkg::LAMP_TWO)
                                  : alarm_pkg::LAMP_NONE;
                end
                if (secs >= alarm_delay) begin
                    cur_mode = alarm_pkg::MODE_SOUNDING;
                    entry_pend = 1'b1;
                end
            end
            alarm_pkg::MODE_SOUNDING: begin
                if (phase == alarm_pkg::PH_ON) begin
                    if (secs >= sound_on) begin
                        lamps = alarm_pkg::LAMP_NONE;
                        secs = 8'd0;
                        phase = alarm_pkg::PH_OFF;
                    end
                end else if (phase == alarm_pkg::PH_OFF) begin
                    if (secs >= sound_off) begin
                        notify = 1'b1;
                        phase = alarm_pkg::PH_DONE;
                    end
                end
            end
            default: begin
                if (press) begin
                    cur_mode = alarm_pkg::MODE_ARMING;
                    entry_pend = 1'b1;
                end
            end
        endcase

        // A press wins over any other move once armed
        if (press && (cur == alarm_pkg::MODE_ARMED || cur == alarm_pkg::MODE_TRIGGERED
                   || cur == alarm_pkg::MODE_SOUNDING)) begin
            cur_mode = alarm_pkg::MODE_OFF;
            entry_pend = 1'b1;
        end

        r.led_one = lamps[0];
        r.led_two = lamps[1];
        r.buzzer  = lamps[2];
        r.mode    = cur_mode;
        r.notify  = notify;
        return r;
    endfunction

    // Offer one request, hold it until taken, then queue its expected result
    task automatic offer_sample(input logic btn, input logic sens, input logic sec,
                                input logic half, input logic typed,
                                input t_alarm_result want);
        t_alarm_result r;
        int            gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        btn_level    <= btn;
        sensor_level <= sens;
        second_pulse <= sec;
        half_pulse   <= half;
        do @(posedge clk); while (!in_ready);
        r = alarm_next(btn, sens, sec, half);
        pending_outputs.push_back(typed ? want : r);
        samples_sent++;
    endtask

    task automatic write_reg(input alarm_pkg::t_cfg_index idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // Drain the block, then load all four delay registers
    task automatic load_settings(input logic [7:0] arm, input logic [7:0] alarm,
                                 input logic [7:0] on_secs, input logic [7:0] off_secs);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        write_reg(alarm_pkg::CFG_ARM_DELAY, arm);
        write_reg(alarm_pkg::CFG_ALARM_DELAY, alarm);
        write_reg(alarm_pkg::CFG_SOUND_ON, on_secs);
        write_reg(alarm_pkg::CFG_SOUND_OFF, off_secs);
        @(posedge clk);
        cfg_we <= 1'b0;
        arm_delay   = arm;
        alarm_delay = alarm;
        sound_on    = on_secs;
        sound_off   = off_secs;
        settings_used++;
    endtask

    // Sample channel driver
    initial begin
        int   p;
        int   k;
        int   press_pct;
        logic btn;
        logic sens;
        logic sec;
        logic half;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = alarm_pkg::CFG_ARM_DELAY;
        cfg_data     = 8'd0;
        in_valid     = 1'b0;
        btn_level    = 1'b1;
        sensor_level = 1'b0;
        second_pulse = 1'b0;
        half_pulse   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        load_settings(8'd1, 8'd1, 8'd1, 8'd0);
        for (k = 0; k < NUM_ROWS; k++)
            offer_sample(DIRECTED[k].btn, DIRECTED[k].sens, DIRECTED[k].sec,
                         DIRECTED[k].half, DIRECTED[k].typed, DIRECTED[k].want);
        in_valid <= 1'b0;

        // Random phases; the second one draws small settings at random
        for (p = 0; p < NUM_SETS; p++) begin
            if (p == 1)
                load_settings(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                              8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
            else
                load_settings(SET_ARM[p], SET_ALARM[p], SET_ON[p], SET_OFF[p]);
            no_idle = (p == LAST_SET);
            for (k = 0; k < SET_COUNT[p]; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any pin pattern
                    btn  = 1'($urandom_range(0, 1));
                    sens = 1'($urandom_range(0, 1));
                    sec  = 1'($urandom_range(0, 1));
                    half = 1'($urandom_range(0, 1));
                end else begin
                    // press often while off or done, rarely elsewhere
                    case (cur_mode)
                        alarm_pkg::MODE_OFF: press_pct = 25;
                        alarm_pkg::MODE_SOUNDING:
                            press_pct = (phase == alarm_pkg::PH_DONE) ? 15 : 2;
                        default: press_pct = 2;
                    endcase
                    if (!prior_btn)
                        btn = ($urandom_range(0, 99) < 70);
                    else
                        btn = !($urandom_range(0, 99) < press_pct);
                    sens = ($urandom_range(0, 99) < 15);
                    sec  = ($urandom_range(0, 99) < SET_SEC[p]);
                    half = 1'($urandom_range(0, 1));
                end
                offer_sample(btn, sens, sec, half, 1'b0, NO_RESULT);
            end
            in_valid <= 1'b0;
        end

        // Drain and let the pipeline settle
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Checked %0d results from %0d samples under %0d delay settings.",
                 results_checked, samples_sent, settings_used);
        $display("Notify pulses seen: %0d; errors: %0d.", notify_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hold off the result side for a long stretch to fill the block
    initial begin
        while (samples_sent < 300) @(posedge clk);
        long_hold <= 1'b1;
        repeat (60) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Result side: random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (!no_idle && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            out_ready <= (stall_left == 0) && !long_hold;
        end
    end

    // Compare each taken result with the oldest expected one
    always @(posedge clk) begin : check_results
        t_alarm_result got;
        t_alarm_result want;
        if (rst_n && out_valid && out_ready) begin
            got.led_one = led_one;
            got.led_two = led_two;
            got.buzzer  = buzzer_on;
            got.mode    = alarm_pkg::t_mode'(mode_code);
            got.notify  = notify_pulse;
            results_checked++;
            if (pending_outputs.size() == 0) begin
                if (errors < 10)
                    $display("Unexpected result: led1 %b led2 %b buzz %b mode %0d notify %b",
                             got.led_one, got.led_two, got.buzzer, got.mode, got.notify);
                errors++;
            end else begin
                want = pending_outputs.pop_front();
                if (want.notify)
                    notify_seen++;
                if (got.led_one !== want.led_one || got.led_two !== want.led_two ||
                    got.buzzer !== want.buzzer || got.mode !== want.mode ||
                    got.notify !== want.notify) begin
                    if (errors < 10)
                        $display({"Mismatch at result %0d: expected led1 %b led2 %b buzz %b ",
                                  "mode %0d notify %b, got led1 %b led2 %b buzz %b ",
                                  "mode %0d notify %b"},
                                 results_checked, want.led_one, want.led_two, want.buzzer,
                                 want.mode, want.notify, got.led_one, got.led_two,
                                 got.buzzer, got.mode, got.notify);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
